// ===== hdl/triangle_pixel_coverage_test_macros.svh =====
// Assertion macros shared by the triangle coverage checker
`ifndef TRIANGLE_PIXEL_COVERAGE_TEST_MACROS_SVH
`define TRIANGLE_PIXEL_COVERAGE_TEST_MACROS_SVH

// General property, sampled on clk_i and quiet while rst_ni is low
`define TPCT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A signal holds while a result transaction is stalled by the receiver
`define TPCT_HOLD(label, sig, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (out_valid_o && !out_ready_i) |=> $stable(sig)) else $error(msg);

`endif

// ===== hdl/tpct_pkg.sv =====
// Types and constants for the triangle pixel coverage test
`default_nettype none

package tpct_pkg;

  localparam int COORD_BITS  = 10;
  localparam int ROW_PIXELS  = 640;
  localparam int COLOUR_W    = 16;
  localparam int OFFSET_W    = 21;

  typedef struct packed {
    logic [COORD_BITS-1:0] first_x;
    logic [COORD_BITS-1:0] first_y;
    logic [COORD_BITS-1:0] second_x;
    logic [COORD_BITS-1:0] second_y;
    logic [COORD_BITS-1:0] third_x;
    logic [COORD_BITS-1:0] third_y;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOUR_W-1:0]   paint_colour;
  } in_t;

  typedef struct packed {
    logic                covered;
    logic [OFFSET_W-1:0] byte_offset;
    logic [COLOUR_W-1:0] write_colour;
  } out_t;

endpackage

`default_nettype wire

// ===== hdl/triangle_pixel_coverage_test.sv =====
// Usage:
//   Input transactions carry three vertices, a pixel and a colour on in_data_i,
//   moved by in_valid_i / in_ready_o. Each yields one result on out_data_o
//   (covered flag, framebuffer byte offset, colour) moved by out_valid_o /
//   out_ready_i, in the order the inputs were taken.
//   The work runs through six register stages: edge vectors, first products,
//   dot products, second products, numerators and denominator, final compare.
//   out_valid_o rises once an accepted input has passed through every stage;
//   while the receiver keeps taking, throughput is one transaction per cycle.
//   The 22 x 22 bit multipliers of the fourth stage set the cycle time.
//   Each stage takes a new item whenever it is empty or its successor moves,
//   so bubbles close up and inputs are still taken while a result waits.
//   When out_ready_i is low the result holds unchanged; once all six stages
//   are full and out_ready_i is low, in_ready_o drops.
//   Reset (rst_ni low, asynchronous) empties the pipeline; no results are
//   pending afterwards. The data registers are not reset.
`default_nettype none

module triangle_pixel_coverage_test (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_ready_o,
  input  tpct_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  wire             out_ready_i,
  output tpct_pkg::out_t  out_data_o
);
  import tpct_pkg::*;

  localparam int NSTAGE = 6;
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W - 1;
  localparam int DOT_W  = PROD_W + 1;
  localparam int MUL_W  = 2 * DOT_W - 1;
  localparam int NUM_W  = MUL_W + 1;
  localparam int SUM_W  = NUM_W + 1;

  // stage enables and valid bits
  logic [NSTAGE-1:0] en;
  logic [NSTAGE-1:0] vld_d, vld_q;

  always_comb begin
    en[NSTAGE-1] = !vld_q[NSTAGE-1] || out_ready_i;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (en[0]) vld_d[0] = in_valid_i;
    for (int k = 1; k < NSTAGE; k++) begin
      if (en[k]) vld_d[k] = vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NSTAGE-1];

  // stage 0: vectors relative to the first vertex, pixel offset
  logic signed [DIFF_W-1:0] e0x_d, e0y_d, e1x_d, e1y_d, qx_d, qy_d;
  logic signed [DIFF_W-1:0] e0x_q, e0y_q, e1x_q, e1y_q, qx_q, qy_q;
  logic [OFFSET_W-1:0]      pix;
  logic [OFFSET_W-1:0]      off_d;
  logic [OFFSET_W-1:0]      off_q [NSTAGE];
  logic [COLOUR_W-1:0]      col_q [NSTAGE];

  function automatic logic signed [DIFF_W-1:0] sub_c(input logic [COORD_BITS-1:0] b,
                                                     input logic [COORD_BITS-1:0] a);
    return $signed({1'b0, b}) - $signed({1'b0, a});
  endfunction

  always_comb begin
    e0x_d = sub_c(in_data_i.second_x, in_data_i.first_x);
    e0y_d = sub_c(in_data_i.second_y, in_data_i.first_y);
    e1x_d = sub_c(in_data_i.third_x,  in_data_i.first_x);
    e1y_d = sub_c(in_data_i.third_y,  in_data_i.first_y);
    qx_d  = sub_c(in_data_i.pixel_x,  in_data_i.first_x);
    qy_d  = sub_c(in_data_i.pixel_y,  in_data_i.first_y);
    pix   = OFFSET_W'(in_data_i.pixel_x)
          + OFFSET_W'(in_data_i.pixel_y) * OFFSET_W'(ROW_PIXELS);
    off_d = {pix[OFFSET_W-2:0], 1'b0};
  end

  // stage 1: products of vector components
  logic signed [PROD_W-1:0] prd_d [10];
  logic signed [PROD_W-1:0] prd_q [10];

  always_comb begin
    prd_d[0] = e0x_q * e0x_q;
    prd_d[1] = e0y_q * e0y_q;
    prd_d[2] = e0x_q * e1x_q;
    prd_d[3] = e0y_q * e1y_q;
    prd_d[4] = e1x_q * e1x_q;
    prd_d[5] = e1y_q * e1y_q;
    prd_d[6] = qx_q * e0x_q;
    prd_d[7] = qy_q * e0y_q;
    prd_d[8] = qx_q * e1x_q;
    prd_d[9] = qy_q * e1y_q;
  end

  // stage 2: dot products
  logic signed [DOT_W-1:0] d00_d, d01_d, d11_d, d20_d, d21_d;
  logic signed [DOT_W-1:0] d00_q, d01_q, d11_q, d20_q, d21_q;

  always_comb begin
    d00_d = DOT_W'(prd_q[0]) + DOT_W'(prd_q[1]);
    d01_d = DOT_W'(prd_q[2]) + DOT_W'(prd_q[3]);
    d11_d = DOT_W'(prd_q[4]) + DOT_W'(prd_q[5]);
    d20_d = DOT_W'(prd_q[6]) + DOT_W'(prd_q[7]);
    d21_d = DOT_W'(prd_q[8]) + DOT_W'(prd_q[9]);
  end

  // stage 3: products of dot products
  logic signed [MUL_W-1:0] m_d [6];
  logic signed [MUL_W-1:0] m_q [6];

  always_comb begin
    m_d[0] = d00_q * d11_q;
    m_d[1] = d01_q * d01_q;
    m_d[2] = d11_q * d20_q;
    m_d[3] = d01_q * d21_q;
    m_d[4] = d00_q * d21_q;
    m_d[5] = d01_q * d20_q;
  end

  // stage 4: denominator and barycentric numerators
  logic signed [NUM_W-1:0] den_d, nv_d, nw_d;
  logic signed [NUM_W-1:0] den_q, nv_q, nw_q;

  always_comb begin
    den_d = NUM_W'(m_q[0]) - NUM_W'(m_q[1]);
    nv_d  = NUM_W'(m_q[2]) - NUM_W'(m_q[3]);
    nw_d  = NUM_W'(m_q[4]) - NUM_W'(m_q[5]);
  end

  // stage 5: coverage decision; degenerate triangles fail den > 0
  logic signed [SUM_W-1:0] nsum;
  logic                    cov_d, cov_q;

  always_comb begin
    nsum  = SUM_W'(nv_q) + SUM_W'(nw_q);
    cov_d = (den_q > 0) && (nv_q >= 0) && (nw_q >= 0) && (nsum <= SUM_W'(den_q));
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      e0x_q    <= e0x_d;
      e0y_q    <= e0y_d;
      e1x_q    <= e1x_d;
      e1y_q    <= e1y_d;
      qx_q     <= qx_d;
      qy_q     <= qy_d;
      off_q[0] <= off_d;
      col_q[0] <= in_data_i.paint_colour;
    end
    if (en[1]) prd_q <= prd_d;
    if (en[2]) begin
      d00_q <= d00_d;
      d01_q <= d01_d;
      d11_q <= d11_d;
      d20_q <= d20_d;
      d21_q <= d21_d;
    end
    if (en[3]) m_q <= m_d;
    if (en[4]) begin
      den_q <= den_d;
      nv_q  <= nv_d;
      nw_q  <= nw_d;
    end
    if (en[5]) cov_q <= cov_d;
    for (int k = 1; k < NSTAGE; k++) begin
      if (en[k]) begin
        off_q[k] <= off_q[k-1];
        col_q[k] <= col_q[k-1];
      end
    end
  end

  always_comb begin
    out_data_o.covered      = cov_q;
    out_data_o.byte_offset  = off_q[NSTAGE-1];
    out_data_o.write_colour = col_q[NSTAGE-1];
  end

endmodule

`default_nettype wire

// ===== hdl/tpct_checker.sv =====
// Port-level checks for the triangle coverage pipeline, bound to the top level
`default_nettype none

`include "triangle_pixel_coverage_test_macros.svh"

module tpct_checker (
  input wire             clk_i,
  input wire             rst_ni,
  input wire             in_valid_i,
  input wire             in_ready_o,
  input tpct_pkg::in_t   in_data_i,
  input wire             out_valid_o,
  input wire             out_ready_i,
  input tpct_pkg::out_t  out_data_o
);
  import tpct_pkg::*;

  // a transaction taken, then the receiver keeps taking
  sequence s_taken_drained;
    (in_valid_i && in_ready_o) ##1 out_ready_i [*5];
  endsequence

  `TPCT_HOLD(a_out_data_hold, out_data_o, "result changed while stalled")

  `TPCT_ASSERT(a_out_valid_hold, (out_valid_o && !out_ready_i) |=> out_valid_o, "result dropped")

  // a taking receiver never blocks the input side
  `TPCT_ASSERT(a_ready_flow, out_ready_i |-> in_ready_o, "input stalled while output drains")

  // a taken transaction reaches the output when the receiver keeps taking
  `TPCT_ASSERT(a_latency, s_taken_drained |=> out_valid_o, "result late")

  `TPCT_ASSERT(a_colour_pass, s_taken_drained |=> (out_data_o.write_colour == $past(in_data_i.paint_colour, 6)), "colour lost")

endmodule

bind triangle_pixel_coverage_test tpct_checker u_tpct_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the triangle pixel coverage test block
`timescale 1ns / 1ps

module testbench;
  import tpct_pkg::*;

  localparam int COORD_MAX = (1 << COORD_BITS) - 1;

  // Expected results in arrival order, with an exact integer barycentric predictor
  class coverage_scoreboard;
    out_t        pending[$];
    int unsigned taken;
    int unsigned checked;
    int unsigned hits;
    int unsigned flat;
    int unsigned errors;

    function void barycentric(input in_t t, output bit hit, output bit degenerate);
      longint ax, ay, e0x, e0y, e1x, e1y, qx, qy;
      longint d00, d01, d11, d20, d21, den, nv, nw;
      ax  = longint'(t.first_x);
      ay  = longint'(t.first_y);
      e0x = longint'(t.second_x) - ax;
      e0y = longint'(t.second_y) - ay;
      e1x = longint'(t.third_x) - ax;
      e1y = longint'(t.third_y) - ay;
      qx  = longint'(t.pixel_x) - ax;
      qy  = longint'(t.pixel_y) - ay;
      d00 = e0x * e0x + e0y * e0y;
      d01 = e0x * e1x + e0y * e1y;
      d11 = e1x * e1x + e1y * e1y;
      d20 = qx * e0x + qy * e0y;
      d21 = qx * e1x + qy * e1y;
      den = d00 * d11 - d01 * d01;
      nv  = d11 * d20 - d01 * d21;
      nw  = d00 * d21 - d01 * d20;
      degenerate = (den <= 0);
      hit = !degenerate && nv >= 0 && nw >= 0 && (nv + nw) <= den;
    endfunction

    function void note_input(input in_t t);
      out_t        want;
      bit          hit;
      bit          degenerate;
      logic [63:0] pix;
      barycentric(t, hit, degenerate);
      pix               = (64'(t.pixel_x) + 64'(t.pixel_y) * ROW_PIXELS) << 1;
      want.covered      = hit;
      want.byte_offset  = pix[OFFSET_W-1:0];
      want.write_colour = t.paint_colour;
      pending.push_back(want);
      taken++;
      if (hit) hits++;
      if (degenerate) flat++;
    endfunction

    function void check_result(input out_t got);
      out_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, covered %0b offset %0d colour %h",
                 $time, got.covered, got.byte_offset, got.write_colour);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.covered !== want.covered) begin
        $display("%0t: covered expected %0b actual %0b", $time, want.covered, got.covered);
        errors++;
      end
      if (got.byte_offset !== want.byte_offset) begin
        $display("%0t: byte_offset expected %0d actual %0d",
                 $time, want.byte_offset, got.byte_offset);
        errors++;
      end
      if (got.write_colour !== want.write_colour) begin
        $display("%0t: write_colour expected %h actual %h",
                 $time, want.write_colour, got.write_colour);
        errors++;
      end
    endfunction
  endclass

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  bit   steady      = 1'b0;

  coverage_scoreboard sb = new();

  triangle_pixel_coverage_test dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Values read at the edge are the ones the block sees at that edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_input(in_data_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= steady || ($urandom_range(0, 99) >= 32);
    end
  end

  function automatic logic [COORD_BITS-1:0] clamp_coord(input int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return COORD_MAX[COORD_BITS-1:0];
    return v[COORD_BITS-1:0];
  endfunction

  function automatic int jitter(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic in_t triangle_item(input int ax, ay, bx, by, cx, cy, px, py,
                                        input logic [COLOUR_W-1:0] colour);
    in_t t;
    t.first_x      = clamp_coord(ax);
    t.first_y      = clamp_coord(ay);
    t.second_x     = clamp_coord(bx);
    t.second_y     = clamp_coord(by);
    t.third_x      = clamp_coord(cx);
    t.third_y      = clamp_coord(cy);
    t.pixel_x      = clamp_coord(px);
    t.pixel_y      = clamp_coord(py);
    t.paint_colour = colour;
    return t;
  endfunction

  // Mostly pixels close to or inside the triangle, so both outcomes stay common
  function automatic in_t random_item();
    in_t t;
    int  mode, sub, ax, ay, bx, by, cx, cy, px, py, s, w, dx, dy, ox, oy, k;
    t    = in_t'({$urandom, $urandom, $urandom});
    mode = $urandom_range(0, 99);
    if (mode < 20) return t;
    ax = $urandom_range(0, COORD_MAX);
    ay = $urandom_range(0, COORD_MAX);
    if ($urandom_range(0, 1) == 0) begin
      bx = $urandom_range(0, COORD_MAX);
      by = $urandom_range(0, COORD_MAX);
      cx = $urandom_range(0, COORD_MAX);
      cy = $urandom_range(0, COORD_MAX);
    end else begin
      bx = clamp_coord(ax + jitter(64));
      by = clamp_coord(ay + jitter(64));
      cx = clamp_coord(ax + jitter(64));
      cy = clamp_coord(ay + jitter(64));
    end
    px = $urandom_range(0, COORD_MAX);
    py = $urandom_range(0, COORD_MAX);
    if (mode < 55) begin
      s  = $urandom_range(0, 256);
      w  = $urandom_range(0, 256 - s);
      px = ax + ((bx - ax) * s + (cx - ax) * w) / 256;
      py = ay + ((by - ay) * s + (cy - ay) * w) / 256;
      if ($urandom_range(0, 3) == 0) begin
        px += jitter(1);
        py += jitter(1);
      end
    end else if (mode < 70) begin
      px = $urandom_range((ax < bx ? (ax < cx ? ax : cx) : (bx < cx ? bx : cx)),
                          (ax > bx ? (ax > cx ? ax : cx) : (bx > cx ? bx : cx)));
      py = $urandom_range((ay < by ? (ay < cy ? ay : cy) : (by < cy ? by : cy)),
                          (ay > by ? (ay > cy ? ay : cy) : (by > cy ? by : cy)));
    end else if (mode < 80) begin
      k = $urandom_range(0, 5);
      case (k)
        0: begin px = ax; py = ay; end
        1: begin px = bx; py = by; end
        2: begin px = cx; py = cy; end
        3: begin px = (ax + bx) / 2; py = (ay + by) / 2; end
        4: begin px = (bx + cx) / 2; py = (by + cy) / 2; end
        default: begin px = (ax + cx) / 2; py = (ay + cy) / 2; end
      endcase
    end else if (mode < 92) begin
      // degenerate triangles: coincident, collinear on a slope, or on one row/column
      sub = $urandom_range(0, 2);
      if (sub == 0) begin
        bx = ax; by = ay; cx = ax; cy = ay;
        if ($urandom_range(0, 1) == 0) begin px = ax; py = ay; end
      end else if (sub == 1) begin
        ax = $urandom_range(200, COORD_MAX - 200);
        ay = $urandom_range(200, COORD_MAX - 200);
        dx = jitter(100);
        dy = jitter(100);
        k  = $urandom_range(0, 2);
        bx = ax + dx; by = ay + dy;
        cx = ax + (k == 0 ? -dx : 2 * dx);
        cy = ay + (k == 0 ? -dy : 2 * dy);
        if ($urandom_range(0, 1) == 0) begin px = ax + dx / 2; py = ay + dy / 2; end
      end else if ($urandom_range(0, 1) == 0) begin
        by = ay; cy = ay; py = ay;
      end else begin
        bx = ax; cx = ax; px = ax;
      end
    end else begin
      ox = $urandom_range(0, 1) ? COORD_MAX - 15 : 0;
      oy = $urandom_range(0, 1) ? COORD_MAX - 15 : 0;
      ax = ox + $urandom_range(0, 15); ay = oy + $urandom_range(0, 15);
      bx = ox + $urandom_range(0, 15); by = oy + $urandom_range(0, 15);
      cx = ox + $urandom_range(0, 15); cy = oy + $urandom_range(0, 15);
      px = ox + $urandom_range(0, 15); py = oy + $urandom_range(0, 15);
    end
    return triangle_item(ax, ay, bx, by, cx, cy, px, py, t.paint_colour);
  endfunction

  // valid drops only when the sender idles; once raised it holds until ready takes the item
  task automatic offer(input in_t item);
    while (!steady && $urandom_range(0, 99) < 32) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  initial begin
    in_t directed[$];
    int  i;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed.push_back('0);
    directed.push_back('1);
    directed.push_back(triangle_item(0, 0, 1023, 0, 0, 1023, 0, 0, 16'h5555));
    directed.push_back(triangle_item(0, 0, 1023, 0, 0, 1023, 1023, 0, 16'hAAAA));
    directed.push_back(triangle_item(0, 0, 1023, 0, 0, 1023, 511, 512, 16'hFFFF));
    directed.push_back(triangle_item(0, 0, 1023, 0, 0, 1023, 512, 512, 16'h0000));
    directed.push_back(triangle_item(0, 0, 1023, 0, 0, 1023, 1023, 1023, 16'hFFFF));
    directed.push_back(triangle_item(0, 0, 0, 1023, 1023, 0, 100, 100, 16'h1234));
    directed.push_back(triangle_item(1023, 1023, 0, 1023, 1023, 0, 1023, 1023, 16'hFFFF));
    directed.push_back(triangle_item(1023, 1023, 0, 1023, 1023, 0, 0, 0, 16'h0001));
    // collinear and coincident vertices cover nothing, even on the line
    directed.push_back(triangle_item(0, 0, 512, 512, 1023, 1023, 256, 256, 16'h8000));
    directed.push_back(triangle_item(300, 300, 300, 300, 300, 300, 300, 300, 16'h00FF));
    directed.push_back(triangle_item(10, 10, 10, 10, 50, 70, 10, 10, 16'hFF00));
    directed.push_back(triangle_item(0, 5, 1023, 5, 40, 5, 500, 5, 16'h7BEF));
    directed.push_back(triangle_item(0, 0, 1023, 1, 1023, 0, 1023, 0, 16'hF800));
    directed.push_back(triangle_item(0, 0, 1023, 1, 1023, 0, 512, 1, 16'h07E0));
    directed.push_back(triangle_item(100, 100, 300, 100, 200, 300, 200, 100, 16'h001F));
    directed.push_back(triangle_item(100, 100, 300, 100, 200, 300, 200, 200, 16'hABCD));
    directed.push_back(triangle_item(100, 100, 300, 100, 200, 300, 200, 99, 16'h4321));
    directed.push_back(triangle_item(100, 100, 300, 100, 200, 300, 99, 100, 16'hBEEF));
    foreach (directed[j]) offer(directed[j]);

    for (i = 0; i < 1200; i++) begin
      steady = (i >= 500 && i < 750);
      offer(random_item());
    end
    steady = 1'b0;
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Checked %0d of %0d pixel tests: %0d covered, %0d on degenerate triangles.",
             sb.checked, sb.taken, sb.hits, sb.flat);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results outstanding", sb.errors, sb.pending.size());
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results outstanding", sb.pending.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/tpct_pkg.sv
hdl/triangle_pixel_coverage_test.sv
hdl/tpct_checker.sv
tb/testbench.sv
